// File: hw/rtl/fat_boot_sector_bpb_check_defines.svh
// Assertion macros shared by the BPB check RTL.
`ifndef FAT_BOOT_SECTOR_BPB_CHECK_DEFINES_SVH
`define FAT_BOOT_SECTOR_BPB_CHECK_DEFINES_SVH
`ifndef SYNTH
`define FBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpb check: same-cycle assertion failed");
`define FBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpb check: next-cycle assertion failed");
`else
`define FBS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/fbs_pkg.sv
// Types, constants and codes shared by the FAT boot sector BPB check.
package fbs_pkg;

    localparam int unsigned HDR_DEPTH = 25;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_DEPTH);
    localparam int unsigned POS_W     = 6;

    localparam logic [POS_W-1:0] HDR_FIRST = 6'd11;
    localparam logic [POS_W-1:0] MIN_BYTES = 6'd36;

    localparam logic [31:0] FAT12_LIMIT = 32'd4085;
    localparam logic [31:0] FAT16_LIMIT = 32'd65525;
    localparam logic [7:0]  MAX_CLUSTER = 8'd128;
    // 32-byte directory entries
    localparam int unsigned DIR_ENTRY_SHIFT = 5;

    localparam logic [2:0] FAIL_NONE     = 3'd0;
    localparam logic [2:0] FAIL_SHORT    = 3'd1;
    localparam logic [2:0] FAIL_SECTOR   = 3'd2;
    localparam logic [2:0] FAIL_CLUSTER  = 3'd3;
    localparam logic [2:0] FAIL_RESERVED = 3'd4;
    localparam logic [2:0] FAIL_FATS     = 3'd5;
    localparam logic [2:0] FAIL_TOTAL    = 3'd6;
    localparam logic [2:0] FAIL_FAT_SIZE = 3'd7;

    localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
    localparam logic [1:0] TYPE_FAT12   = 2'd1;
    localparam logic [1:0] TYPE_FAT16   = 2'd2;
    localparam logic [1:0] TYPE_FAT32   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic        bpb_ok;
        logic [2:0]  fail_reason;
        logic [1:0]  fat_type;
        logic [15:0] sector_bytes;
        logic [7:0]  cluster_sectors;
        logic [15:0] reserved_count;
        logic [7:0]  fat_copies;
        logic [15:0] root_entries;
        logic [31:0] volume_sectors;
        logic [15:0] fat_sectors;
        logic [24:0] data_start;
        logic [31:0] cluster_total;
    } t_out;

    typedef struct packed {
        logic take_byte;
        logic stage1;
        logic stage2;
        logic stage3;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last_beat;
        logic out_free;
    } t_stat;

endpackage

// File: hw/rtl/fbs_ctrl.sv
// Sequencer for the BPB check: byte collection, evaluation steps, result hand-off.
`include "fat_boot_sector_bpb_check_defines.svh"

module fbs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fbs_pkg::t_stat i_stat,
    output fbs_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] ST_COLLECT = 3'd0;
    localparam logic [2:0] ST_S1      = 3'd1;
    localparam logic [2:0] ST_S2      = 3'd2;
    localparam logic [2:0] ST_S3      = 3'd3;
    localparam logic [2:0] ST_LOAD    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       in_fire;

    assign o_in_ready = (r_state == ST_COLLECT);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.take_byte = in_fire;
        unique case (r_state)
            ST_COLLECT: begin
                if (in_fire && i_stat.last_beat) begin
                    n_state = ST_S1;
                end
            end
            ST_S1: begin
                o_cmd.stage1 = 1'b1;
                n_state = ST_S2;
            end
            ST_S2: begin
                o_cmd.stage2 = 1'b1;
                n_state = ST_S3;
            end
            ST_S3: begin
                o_cmd.stage3 = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                // hold until the output register can take the beat
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    `FBS_ASSERT_NEXT(a_last_starts_eval, i_clk, i_rst_n, in_fire && i_stat.last_beat,
        r_state == ST_S1)
    `FBS_ASSERT_NEXT(a_load_returns, i_clk, i_rst_n, r_state == ST_LOAD && i_stat.out_free,
        r_state == ST_COLLECT)
    `FBS_ASSERT_SAME(a_eval_follows_s1, i_clk, i_rst_n, r_state == ST_S2,
        $past(r_state) == ST_S1)

endmodule

// File: hw/rtl/fbs_datapath.sv
// Byte counter, header store, BPB decode and derived-value pipeline.
`include "fat_boot_sector_bpb_check_defines.svh"

module fbs_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fbs_pkg::t_in   i_in_data,
    input  fbs_pkg::t_cmd  i_cmd,
    output fbs_pkg::t_stat o_stat,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output fbs_pkg::t_out  o_out_data
);

    localparam int unsigned ROOT_SUM_W = 22;
    localparam int unsigned ROOT_W     = 15;

    // byte counter and header store
    logic [fbs_pkg::POS_W-1:0]     r_pos;
    logic [fbs_pkg::POS_W-1:0]     pos_inc;
    logic [fbs_pkg::POS_W-1:0]     pos_off;
    logic                          r_short;
    logic [7:0]                    r_store [fbs_pkg::HDR_DEPTH];

    // decoded fields
    logic [15:0] bps;
    logic [7:0]  spc;
    logic [15:0] rsv;
    logic [7:0]  nf;
    logic [15:0] ents;
    logic [15:0] t16;
    logic [15:0] fsz;
    logic [31:0] tot;
    logic [3:0]  bps_sh;
    logic        bps_ok;
    logic [2:0]  spc_sh;
    logic        spc_pow2;
    logic [2:0]  reason;
    logic [ROOT_SUM_W-1:0] root_sum;
    logic [ROOT_SUM_W-1:0] root_full;

    // evaluation registers
    logic [15:0]       r_bps;
    logic [7:0]        r_spc;
    logic [15:0]       r_rsv;
    logic [7:0]        r_nf;
    logic [15:0]       r_ents;
    logic [31:0]       r_tot;
    logic [15:0]       r_fsz;
    logic [2:0]        r_reason;
    logic [2:0]        r_spc_sh;
    logic [23:0]       r_prod;
    logic [ROOT_W-1:0] r_root;
    logic [24:0]       r_first;
    logic [31:0]       r_clus;
    logic [31:0]       first_ext;
    logic [31:0]       diff;

    logic          r_out_valid;
    fbs_pkg::t_out r_out;
    fbs_pkg::t_out n_out;

    assign pos_inc = (r_pos < fbs_pkg::MIN_BYTES) ? r_pos + 6'd1 : r_pos;
    assign pos_off = r_pos - fbs_pkg::HDR_FIRST;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.take_byte) begin
            r_pos <= i_in_data.last_byte ? '0 : pos_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            if (r_pos >= fbs_pkg::HDR_FIRST && r_pos < fbs_pkg::MIN_BYTES) begin
                r_store[pos_off[fbs_pkg::HDR_IDX_W-1:0]] <= i_in_data.data_byte;
            end
            if (i_in_data.last_byte) begin
                r_short <= (pos_inc < fbs_pkg::MIN_BYTES);
            end
        end
    end

    // little-endian fields, store index = offset - 11
    assign bps  = {r_store[1], r_store[0]};
    assign spc  = r_store[2];
    assign rsv  = {r_store[4], r_store[3]};
    assign nf   = r_store[5];
    assign ents = {r_store[7], r_store[6]};
    assign t16  = {r_store[9], r_store[8]};
    assign fsz  = {r_store[12], r_store[11]};
    assign tot  = (t16 != 16'd0) ? {16'd0, t16}
                                 : {r_store[24], r_store[23], r_store[22], r_store[21]};

    always_comb begin
        bps_ok = 1'b1;
        unique case (bps)
            16'd128:  bps_sh = 4'd7;
            16'd256:  bps_sh = 4'd8;
            16'd512:  bps_sh = 4'd9;
            16'd1024: bps_sh = 4'd10;
            16'd2048: bps_sh = 4'd11;
            16'd4096: bps_sh = 4'd12;
            default: begin
                bps_sh = 4'd7;
                bps_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        spc_pow2 = 1'b1;
        unique case (spc)
            8'd1:   spc_sh = 3'd0;
            8'd2:   spc_sh = 3'd1;
            8'd4:   spc_sh = 3'd2;
            8'd8:   spc_sh = 3'd3;
            8'd16:  spc_sh = 3'd4;
            8'd32:  spc_sh = 3'd5;
            8'd64:  spc_sh = 3'd6;
            8'd128: spc_sh = 3'd7;
            default: begin
                spc_sh   = 3'd0;
                spc_pow2 = 1'b0;
            end
        endcase
    end

    always_comb begin
        priority if (!bps_ok) begin
            reason = fbs_pkg::FAIL_SECTOR;
        end else if (!(spc_pow2 && spc <= fbs_pkg::MAX_CLUSTER)) begin
            reason = fbs_pkg::FAIL_CLUSTER;
        end else if (rsv == 16'd0) begin
            reason = fbs_pkg::FAIL_RESERVED;
        end else if (nf == 8'd0) begin
            reason = fbs_pkg::FAIL_FATS;
        end else if (tot == 32'd0) begin
            reason = fbs_pkg::FAIL_TOTAL;
        end else if (fsz == 16'd0) begin
            reason = fbs_pkg::FAIL_FAT_SIZE;
        end else begin
            reason = fbs_pkg::FAIL_NONE;
        end
    end

    // round root directory bytes up to whole sectors
    assign root_sum  = (ROOT_SUM_W'(ents) << fbs_pkg::DIR_ENTRY_SHIFT)
                     + ROOT_SUM_W'(bps) - ROOT_SUM_W'(1);
    assign root_full = root_sum >> bps_sh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.stage1) begin
            r_bps    <= bps;
            r_spc    <= spc;
            r_rsv    <= rsv;
            r_nf     <= nf;
            r_ents   <= ents;
            r_tot    <= tot;
            r_fsz    <= fsz;
            r_reason <= reason;
            r_spc_sh <= spc_sh;
            r_prod   <= {16'd0, nf} * {8'd0, fsz};
            r_root   <= root_full[ROOT_W-1:0];
        end
        if (i_cmd.stage2) begin
            r_first <= 25'(r_rsv) + 25'(r_prod) + 25'(r_root);
        end
        if (i_cmd.stage3) begin
            r_clus <= (r_tot > first_ext) ? (diff >> r_spc_sh) : 32'd0;
        end
    end

    assign first_ext = {7'd0, r_first};
    assign diff      = r_tot - first_ext;

    always_comb begin
        n_out = '0;
        if (r_short) begin
            n_out.fail_reason = fbs_pkg::FAIL_SHORT;
        end else begin
            n_out.fail_reason     = r_reason;
            n_out.sector_bytes    = r_bps;
            n_out.cluster_sectors = r_spc;
            n_out.reserved_count  = r_rsv;
            n_out.fat_copies      = r_nf;
            n_out.root_entries    = r_ents;
            n_out.volume_sectors  = r_tot;
            n_out.fat_sectors     = r_fsz;
            if (r_reason == fbs_pkg::FAIL_NONE) begin
                n_out.bpb_ok        = 1'b1;
                n_out.data_start    = r_first;
                n_out.cluster_total = r_clus;
                priority if (r_clus < fbs_pkg::FAT12_LIMIT) begin
                    n_out.fat_type = fbs_pkg::TYPE_FAT12;
                end else if (r_clus < fbs_pkg::FAT16_LIMIT) begin
                    n_out.fat_type = fbs_pkg::TYPE_FAT16;
                end else begin
                    n_out.fat_type = fbs_pkg::TYPE_FAT32;
                end
            end else begin
                n_out.fat_type = fbs_pkg::TYPE_UNKNOWN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;
    assign o_stat.last_beat = i_in_data.last_byte;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    `FBS_ASSERT_SAME(a_pos_saturates, i_clk, i_rst_n, 1'b1, r_pos <= fbs_pkg::MIN_BYTES)
    `FBS_ASSERT_NEXT(a_load_shows_beat, i_clk, i_rst_n, i_cmd.load_out, r_out_valid)
    `FBS_ASSERT_SAME(a_verdict_matches, i_clk, i_rst_n, r_out_valid,
        r_out.bpb_ok == (r_out.fail_reason == fbs_pkg::FAIL_NONE))

endmodule

// File: hw/rtl/fat_boot_sector_bpb_check.sv
// Result: the beat is loaded once the last byte has passed the evaluation steps.
// Throughput: one byte per cycle while a sector streams in; after its last byte the
// input stalls for the 4 evaluation steps (decode, FAT-area sum, cluster shift, load),
// longer if the previous result still sits unaccepted in the output register.
// Reset: synchronous, active low; clears the byte count, sequencer and output valid.
module fat_boot_sector_bpb_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fbs_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fbs_pkg::t_out o_out_data
);

    fbs_pkg::t_cmd  cmd;
    fbs_pkg::t_stat stat;

    fbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fbs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
